[sv/lcwc_pkg.sv]
// lcwc_pkg: widths, register map, reset values and config struct for the
// load cell weight conditioner; used by every other file of the block
`default_nettype none

package lcwc_pkg;

    localparam int CH_SEL_W   = 2;
    localparam int SAMPLE_W   = 24;
    localparam int WEIGHT_W   = 24;
    localparam int TOTAL_W    = 26;
    localparam int NUM_CAL    = 4;
    localparam int CAL_W      = 56;
    localparam int OFFSET_W   = 24;
    localparam int SCALE_W    = 32;
    localparam int MASK_W     = 4;
    localparam int THR_W      = 24;
    localparam int ALPHA_W    = 9;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = 3;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 33;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 34;
    localparam int FRAC_SHIFT = 16;

    localparam int NUM_CHANNELS_DEF = 4;

    localparam logic [IDX_W-1:0] REG_CAL0  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL2  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL3  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MASK  = 3'd4;
    localparam logic [IDX_W-1:0] REG_THR   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ALPHA = 3'd6;

    localparam logic [THR_W-1:0]   THR_RESET   = 24'd2560;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd179;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 9'd256;
    localparam logic [WEIGHT_W-1:0] W_MAX      = {WEIGHT_W{1'b1}};

    typedef struct packed {
        logic [NUM_CAL-1:0][CAL_W-1:0] cal;
        logic [MASK_W-1:0]             mask;
        logic [THR_W-1:0]              thr;
        logic [ALPHA_W-1:0]            alpha;
    } t_cfg;

endpackage

`default_nettype wire

[sv/lcwc_if.sv]
// lcwc_req_if / lcwc_res_if: valid-ready channels for sample requests and
// weight results; depends on lcwc_pkg
`default_nettype none

interface lcwc_req_if;
    import lcwc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CH_SEL_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface lcwc_res_if;
    import lcwc_pkg::*;
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic                uncalibrated;
    logic                total_valid;
    logic [TOTAL_W-1:0]  weight_sum;
    modport source (output valid, output weight, output uncalibrated,
                    output total_valid, output weight_sum, input ready);
    modport sink   (input valid, input weight, input uncalibrated,
                    input total_valid, input weight_sum, output ready);
endinterface

`default_nettype wire

[sv/load_cell_weight_conditioner.sv]
// load_cell_weight_conditioner: top level, sequencer around one shared multiplier
// depends on lcwc_pkg, lcwc_if, lcwc_regs, lcwc_mul
//
//   channel  | dir | handshake            | payload
//   i_req    | in  | valid/ready          | channel, sample
//   o_res    | out | valid/ready          | weight, uncalibrated, total_valid, weight_sum
//   apb      | in  | psel/penable, pready | paddr, pwdata, prdata (64 bit, 8-byte steps)
//
// a request passes through MUL1, SAT, BL1, BL2, BL3 and DONE when smoothed, MUL1,
// SAT and DONE when the jump bypasses the blend, MUL1 and DONE when uncalibrated;
// the multiplier serves three products in turn. i_req.ready is high only in idle.
// synchronous active-low reset clears the sequencer, stored weights and report
// flags. a result waiting in the output register holds the last step until taken.
`default_nettype none

module load_cell_weight_conditioner #(
    parameter int NUM_CHANNELS = lcwc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lcwc_req_if.sink                         i_req,
    lcwc_res_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcwc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lcwc_pkg::DATA_W-1:0] pwdata,
    output logic [lcwc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import lcwc_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_SAT  = 3'd2;
    localparam logic [2:0] S_BL1  = 3'd3;
    localparam logic [2:0] S_BL2  = 3'd4;
    localparam logic [2:0] S_BL3  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    t_cfg cfg;

    lcwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [2:0]                 r_state;
    logic [CH_SEL_W-1:0]        r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_uncal;
    logic [WEIGHT_W-1:0]        r_w;
    logic [WEIGHT_W-1:0]        r_res;
    logic [ACC_W-1:0]           r_acc;
    logic [WEIGHT_W-1:0]        r_last [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    r_rep;

    logic                r_out_valid;
    logic [WEIGHT_W-1:0] r_out_weight;
    logic                r_out_uncal;
    logic                r_out_tvalid;
    logic [TOTAL_W-1:0]  r_out_total;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    lcwc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    logic [CAL_W-1:0]           cal_sel;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [SCALE_W-1:0]  scale;
    logic                       ch_ok;
    logic                       uncal;
    logic [CH_W-1:0]            w_idx;
    logic [WEIGHT_W-1:0]        prev;
    logic signed [MUL_A_W-1:0]  diff;
    logic [ALPHA_W-1:0]         alpha;
    logic [ALPHA_W-1:0]         alpha_inv;
    logic [WEIGHT_W-1:0]        w_sat;
    logic [WEIGHT_W-1:0]        delta;
    logic [ACC_W-1:0]           blend;
    logic                       out_free;
    logic                       all_rep;
    logic [TOTAL_W-1:0]         total;

    assign cal_sel   = cfg.cal[r_ch];
    assign offset    = cal_sel[OFFSET_W-1:0];
    assign scale     = cal_sel[CAL_W-1:OFFSET_W];
    assign ch_ok     = 32'(r_ch) < NUM_CHANNELS;
    assign uncal     = !ch_ok || !cfg.mask[r_ch] || (scale == '0);
    assign w_idx     = r_ch[CH_W-1:0];
    assign prev      = r_last[w_idx];
    assign diff      = MUL_A_W'(offset) - MUL_A_W'(r_sample);
    assign alpha     = (cfg.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha;
    assign alpha_inv = ALPHA_FULL - alpha;
    assign out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        unique case (r_state)
            S_MUL1: begin
                mul_a = diff;
                mul_b = MUL_B_W'(scale);
            end
            S_BL1: begin
                mul_a = MUL_A_W'(alpha);
                mul_b = MUL_B_W'(r_w);
            end
            S_BL2: begin
                mul_a = MUL_A_W'(alpha_inv);
                mul_b = MUL_B_W'(prev);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product is Q24 grams; keep Q8 and saturate
    always_comb begin
        if (mul_p[MUL_P_W-1] || (mul_p == '0)) begin
            w_sat = '0;
        end else if (|mul_p[MUL_P_W-2:FRAC_SHIFT+WEIGHT_W]) begin
            w_sat = W_MAX;
        end else begin
            w_sat = mul_p[FRAC_SHIFT+WEIGHT_W-1:FRAC_SHIFT];
        end
    end

    assign delta = (w_sat > prev) ? (w_sat - prev) : (prev - w_sat);
    assign blend = r_acc + mul_p[ACC_W-1:0] + ACC_W'(128);

    always_comb begin
        logic [WEIGHT_W-1:0] wv;
        all_rep = 1'b1;
        total   = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            wv = (CH_W'(i) == w_idx) ? r_res : r_last[i];
            total = total + TOTAL_W'(wv);
            all_rep = all_rep && (r_rep[i] || (CH_W'(i) == w_idx));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_ch     <= i_req.channel;
                        r_sample <= i_req.sample;
                        r_state  <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_uncal <= uncal;
                    r_state <= uncal ? S_DONE : S_SAT;
                end
                S_SAT: begin
                    r_w <= w_sat;
                    if (delta > cfg.thr) begin
                        r_res   <= w_sat;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BL1;
                    end
                end
                S_BL1: begin
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_acc   <= mul_p[ACC_W-1:0];
                    r_state <= S_BL3;
                end
                S_BL3: begin
                    r_res   <= (|blend[ACC_W-1:WEIGHT_W+8]) ? W_MAX
                                                           : blend[WEIGHT_W+7:8];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_uncal) begin
                            r_out_weight <= '0;
                            r_out_uncal  <= 1'b1;
                            r_out_tvalid <= 1'b0;
                            r_out_total  <= '0;
                        end else begin
                            r_last[w_idx] <= r_res;
                            r_out_weight  <= r_res;
                            r_out_uncal   <= 1'b0;
                            r_out_tvalid  <= all_rep;
                            r_out_total   <= all_rep ? total : '0;
                            if (all_rep) begin
                                r_rep <= '0;
                            end else begin
                                r_rep[w_idx] <= 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.weight       = r_out_weight;
    assign o_res.uncalibrated = r_out_uncal;
    assign o_res.total_valid  = r_out_tvalid;
    assign o_res.weight_sum   = r_out_total;

endmodule

`default_nettype wire

[sv/lcwc_regs.sv]
// lcwc_regs: apb-style configuration registers, 64-bit data at 8-byte steps
// depends on lcwc_pkg
`default_nettype none

module lcwc_regs (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [lcwc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lcwc_pkg::DATA_W-1:0] pwdata,
    output logic [lcwc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lcwc_pkg::t_cfg              o_cfg
);
    import lcwc_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] idx;
    logic             wr;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal   <= '0;
            r_cfg.mask  <= '0;
            r_cfg.thr   <= THR_RESET;
            r_cfg.alpha <= ALPHA_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_CAL0:  r_cfg.cal[0] <= pwdata[CAL_W-1:0];
                REG_CAL1:  r_cfg.cal[1] <= pwdata[CAL_W-1:0];
                REG_CAL2:  r_cfg.cal[2] <= pwdata[CAL_W-1:0];
                REG_CAL3:  r_cfg.cal[3] <= pwdata[CAL_W-1:0];
                REG_MASK:  r_cfg.mask   <= pwdata[MASK_W-1:0];
                REG_THR:   r_cfg.thr    <= pwdata[THR_W-1:0];
                REG_ALPHA: r_cfg.alpha  <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CAL0:  prdata = DATA_W'(r_cfg.cal[0]);
            REG_CAL1:  prdata = DATA_W'(r_cfg.cal[1]);
            REG_CAL2:  prdata = DATA_W'(r_cfg.cal[2]);
            REG_CAL3:  prdata = DATA_W'(r_cfg.cal[3]);
            REG_MASK:  prdata = DATA_W'(r_cfg.mask);
            REG_THR:   prdata = DATA_W'(r_cfg.thr);
            REG_ALPHA: prdata = DATA_W'(r_cfg.alpha);
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/lcwc_mul.sv]
// lcwc_mul: shared registered signed multiplier used for the scale product
// and both blend terms; depends on lcwc_pkg
`default_nettype none

module lcwc_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [lcwc_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [lcwc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [lcwc_pkg::MUL_P_W-1:0]      o_p
);
    import lcwc_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire
